/* sv/ftf_pkg.sv */
`default_nettype none
package ftf_pkg;

  localparam int unsigned TABLE_ENTRIES_DEFAULT = 16;
  localparam logic [31:0] LOCAL_RESET = 32'h0A00_000A;
  localparam logic [15:0] ETHER_IPV4 = 16'h0800;
  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    V_NOT_IPV4    = 3'd0,
    V_LOCAL       = 3'd1,
    V_BLOCKED     = 3'd2,
    V_COUNTED     = 3'd3,
    V_NEW         = 3'd4,
    V_FULL        = 3'd5,
    V_BANNED      = 3'd6,
    V_BAN_IGNORED = 3'd7
  } verdict_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic     load;      // latch the accepted input word
    logic     rd_first;  // issue the first table read
    logic     scan_step; // advance the scan by one entry
    logic     finish;    // commit state and capture the result
    verdict_t verdict;   // result kind for finish
    logic     emit;      // move the captured result to the output register
  } ctrl_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic is_ban;
    logic ban_ok;
    logic not_ipv4;
    logic is_local;
    logic empty;
    logic full;
    logic hit;
    logic hit_banned;
    logic last;
  } ctrl_status_t;

endpackage
`default_nettype wire

/* sv/flow_table_firewall.sv */
`default_nettype none
// Flow table firewall. Each input word is a parsed packet header or a ban request and yields
// one result word. A packet header that reaches the table is matched against the filled
// entries one per cycle over the single read port of the flow memory, stopping at the first
// match; ban requests and ignored packets skip the scan. The next word is accepted only after
// the result has moved to the output register, which waits while the output is stalled.
// A new input word is taken while the previous result still waits at the output.
// local_address is written through the cfg channel, which is always ready, and may only
// be changed while the block is idle.
module flow_table_firewall #(
  parameter int unsigned TABLE_ENTRIES = ftf_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        req_type,
  input  wire logic [15:0] ether_type,
  input  wire logic [31:0] source_ip,
  input  wire logic [31:0] dest_ip,
  input  wire logic [7:0]  proto,
  input  wire logic [15:0] source_port,
  input  wire logic [15:0] dest_port,
  input  wire logic [3:0]  ban_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       verdict,
  output logic [3:0]       entry_index,
  output logic [31:0]      packet_count
);
  import ftf_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  ftf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  ftf_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .req_type     (req_type),
    .ether_type   (ether_type),
    .source_ip    (source_ip),
    .dest_ip      (dest_ip),
    .proto        (proto),
    .source_port  (source_port),
    .dest_port    (dest_port),
    .ban_index    (ban_index),
    .cmd          (cmd),
    .status       (status),
    .verdict      (verdict),
    .entry_index  (entry_index),
    .packet_count (packet_count)
  );

endmodule
`default_nettype wire

/* sv/ftf_ctrl.sv */
`default_nettype none
module ftf_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire ftf_pkg::ctrl_status_t status,
  output ftf_pkg::ctrl_cmd_t         cmd
);
  import ftf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_BAN,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.verdict = V_NOT_IPV4;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.rd_first = 1'b1;
        if (status.is_ban) begin
          if (status.ban_ok) begin
            state_next = S_BAN;
          end else begin
            cmd.finish  = 1'b1;
            cmd.verdict = V_BAN_IGNORED;
            state_next  = S_EMIT;
          end
        end else if (status.not_ipv4) begin
          cmd.finish  = 1'b1;
          cmd.verdict = V_NOT_IPV4;
          state_next  = S_EMIT;
        end else if (status.is_local) begin
          cmd.finish  = 1'b1;
          cmd.verdict = V_LOCAL;
          state_next  = S_EMIT;
        end else if (status.empty) begin
          cmd.finish  = 1'b1;
          cmd.verdict = V_NEW;
          state_next  = S_EMIT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_BAN: begin
        cmd.finish  = 1'b1;
        cmd.verdict = V_BANNED;
        state_next  = S_EMIT;
      end
      S_SCAN: begin
        if (status.hit) begin
          cmd.finish  = 1'b1;
          cmd.verdict = status.hit_banned ? V_BLOCKED : V_COUNTED;
          state_next  = S_EMIT;
        end else if (status.last) begin
          cmd.finish  = 1'b1;
          cmd.verdict = status.full ? V_FULL : V_NEW;
          state_next  = S_EMIT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/ftf_datapath.sv */
`default_nettype none
module ftf_datapath #(
  parameter int unsigned TABLE_ENTRIES = ftf_pkg::TABLE_ENTRIES_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  input  wire logic [31:0]           cfg_data,
  input  wire logic                  req_type,
  input  wire logic [15:0]           ether_type,
  input  wire logic [31:0]           source_ip,
  input  wire logic [31:0]           dest_ip,
  input  wire logic [7:0]            proto,
  input  wire logic [15:0]           source_port,
  input  wire logic [15:0]           dest_port,
  input  wire logic [3:0]            ban_index,
  input  wire ftf_pkg::ctrl_cmd_t    cmd,
  output ftf_pkg::ctrl_status_t      status,
  output logic [2:0]                 verdict,
  output logic [3:0]                 entry_index,
  output logic [31:0]                packet_count
);
  import ftf_pkg::*;

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  protocol;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] count;
  } flow_entry_t;

  flow_entry_t mem [TABLE_ENTRIES];
  flow_entry_t rd_data;
  flow_entry_t wr_data;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic             wr_en;

  logic [31:0] local_address;
  logic [TABLE_ENTRIES-1:0] banned;
  logic [CNT_W-1:0] filled;
  logic [IDX_W-1:0] cmp_idx;
  logic [IDX_W-1:0] ban_ext;
  logic [IDX_W-1:0] new_idx;
  logic [31:0]      count_inc;

  // latched input word
  logic        it_req;
  logic [15:0] it_ether;
  logic [31:0] it_sip;
  logic [31:0] it_dip;
  logic [7:0]  it_proto;
  logic [15:0] it_sport;
  logic [15:0] it_dport;
  logic [3:0]  it_ban;

  // captured result awaiting the output register
  verdict_t         res_verdict;
  logic [IDX_W-1:0] res_idx;
  logic [31:0]      res_count;

  assign ban_ext   = IDX_W'(it_ban);
  assign new_idx   = filled[IDX_W-1:0];
  assign count_inc = (rd_data.count == COUNT_MAX) ? rd_data.count : rd_data.count + 32'd1;

  always_comb begin
    status.is_ban     = it_req;
    status.ban_ok     = 32'(it_ban) < 32'(filled);
    status.not_ipv4   = (it_ether != ETHER_IPV4);
    status.is_local   = (it_sip == local_address) || (it_dip == local_address);
    status.empty      = (filled == '0);
    status.full       = (filled == CNT_W'(TABLE_ENTRIES));
    status.hit        = (rd_data.src_ip == it_sip) && (rd_data.dst_ip == it_dip) &&
                        (rd_data.protocol == it_proto) && (rd_data.dst_port == it_dport);
    status.hit_banned = banned[cmp_idx];
    status.last       = (CNT_W'(cmp_idx) + CNT_W'(1)) == filled;
  end

  always_comb begin
    rd_en   = cmd.rd_first || cmd.scan_step;
    rd_addr = cmd.rd_first ? (it_req ? ban_ext : '0) : cmp_idx + IDX_W'(1);
    wr_en   = 1'b0;
    wr_addr = cmp_idx;
    wr_data = rd_data;
    if (cmd.finish) begin
      case (cmd.verdict)
        V_COUNTED: begin
          wr_en         = 1'b1;
          wr_data.count = count_inc;
        end
        V_NEW: begin
          wr_en            = 1'b1;
          wr_addr          = new_idx;
          wr_data.src_ip   = it_sip;
          wr_data.dst_ip   = it_dip;
          wr_data.protocol = it_proto;
          wr_data.src_port = it_sport;
          wr_data.dst_port = it_dport;
          wr_data.count    = 32'd1;
        end
        default: begin
          wr_en = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      local_address <= LOCAL_RESET;
      banned        <= '0;
      filled        <= '0;
    end else begin
      if (cfg_valid) begin
        local_address <= cfg_data;
      end
      if (cmd.finish && cmd.verdict == V_BANNED) begin
        banned[cmp_idx] <= 1'b1;
      end
      if (cmd.finish && cmd.verdict == V_NEW) begin
        banned[new_idx] <= 1'b0;
        filled          <= filled + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it_req   <= req_type;
      it_ether <= ether_type;
      it_sip   <= source_ip;
      it_dip   <= dest_ip;
      it_proto <= proto;
      it_sport <= source_port;
      it_dport <= dest_port;
      it_ban   <= ban_index;
    end
    if (cmd.rd_first) begin
      cmp_idx <= it_req ? ban_ext : '0;
    end else if (cmd.scan_step) begin
      cmp_idx <= cmp_idx + IDX_W'(1);
    end
    if (cmd.finish) begin
      res_verdict <= cmd.verdict;
      case (cmd.verdict)
        V_BLOCKED, V_BANNED: begin
          res_idx   <= cmp_idx;
          res_count <= rd_data.count;
        end
        V_COUNTED: begin
          res_idx   <= cmp_idx;
          res_count <= count_inc;
        end
        V_NEW: begin
          res_idx   <= new_idx;
          res_count <= 32'd1;
        end
        default: begin
          res_idx   <= '0;
          res_count <= '0;
        end
      endcase
    end
    if (cmd.emit) begin
      verdict      <= res_verdict;
      entry_index  <= 4'(res_idx);
      packet_count <= res_count;
    end
  end

endmodule
`default_nettype wire

/* sv/ftf_checker.sv */
`default_nettype none
module ftf_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  verdict,
  input wire logic [3:0]  entry_index,
  input wire logic [31:0] packet_count
);
  import ftf_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(entry_index) &&
                                $stable(packet_count))
    else $error("result word changed while stalled");

  a_no_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && (verdict == V_NOT_IPV4 || verdict == V_LOCAL || verdict == V_FULL ||
                  verdict == V_BAN_IGNORED) |-> entry_index == 4'd0 && packet_count == 32'd0)
    else $error("entry fields set on a result without an entry");

  a_new_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == V_NEW |-> packet_count == 32'd1)
    else $error("new entry without a count of one");

  a_counted: assert property (@(posedge clk) disable iff (rst)
    out_valid && verdict == V_COUNTED |-> packet_count > 32'd1)
    else $error("counted entry with a count below two");

endmodule

bind flow_table_firewall ftf_checker u_ftf_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .verdict      (verdict),
  .entry_index  (entry_index),
  .packet_count (packet_count)
);
`default_nettype wire

/* verif/flow_table_firewall_tb.sv */
module flow_table_firewall_tb;
  import ftf_pkg::*;

  localparam int unsigned TABLE_DEPTH = TABLE_ENTRIES_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned WORDS_PER_PHASE = 217;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam logic REQ_PACKET = 1'b0;
  localparam logic REQ_BAN = 1'b1;
  localparam logic [31:0] HOST_A = 32'hC0A8_0001;
  localparam logic [31:0] HOST_B = 32'h0808_0808;
  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_HOLD} rx_mode_t;

  typedef struct packed {
    logic        req_type;
    logic [15:0] ether_type;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
    logic [7:0]  proto;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [3:0]  ban_index;
  } fw_word_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [3:0]  entry_index;
    logic [31:0] packet_count;
  } fw_outcome_t;

  typedef struct {
    fw_word_t    word;
    bit          typed;
    fw_outcome_t outcome;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = 1'b0;
  logic [15:0] ether_type = '0;
  logic [31:0] source_ip = '0;
  logic [31:0] dest_ip = '0;
  logic [7:0]  proto = '0;
  logic [15:0] source_port = '0;
  logic [15:0] dest_port = '0;
  logic [3:0]  ban_index = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  verdict;
  logic [3:0]  entry_index;
  logic [31:0] packet_count;

  // flow table as the block should hold it
  logic [31:0] tbl_sip [TABLE_DEPTH];
  logic [31:0] tbl_dip [TABLE_DEPTH];
  logic [7:0]  tbl_proto [TABLE_DEPTH];
  logic [15:0] tbl_dport [TABLE_DEPTH];
  logic [31:0] tbl_cnt [TABLE_DEPTH];
  bit          tbl_ban [TABLE_DEPTH];
  int unsigned fill_cnt = 0;
  logic [31:0] local_m = LOCAL_RESET;

  fw_outcome_t outcome_q [$];
  plan_row_t   plan [$];
  logic        word_typed = 1'b0;
  fw_outcome_t word_fixed = '0;
  int unsigned burst_left = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;

  flow_table_firewall u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .ether_type   (ether_type),
    .source_ip    (source_ip),
    .dest_ip      (dest_ip),
    .proto        (proto),
    .source_port  (source_port),
    .dest_port    (dest_port),
    .ban_index    (ban_index),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .verdict      (verdict),
    .entry_index  (entry_index),
    .packet_count (packet_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic fw_outcome_t classify_word(input fw_word_t w);
    fw_outcome_t r;
    int unsigned i;
    r = '0;
    r.verdict = V_NOT_IPV4;
    if (w.req_type == REQ_BAN) begin
      if (w.ban_index < fill_cnt) begin
        tbl_ban[w.ban_index] = 1'b1;
        r.verdict = V_BANNED;
        r.entry_index = w.ban_index;
        r.packet_count = tbl_cnt[w.ban_index];
      end else begin
        r.verdict = V_BAN_IGNORED;
      end
      return r;
    end
    if (w.ether_type != ETHER_IPV4) return r;
    if (w.source_ip == local_m || w.dest_ip == local_m) begin
      r.verdict = V_LOCAL;
      return r;
    end
    for (i = 0; i < fill_cnt; i++) begin
      if (tbl_sip[i] == w.source_ip && tbl_dip[i] == w.dest_ip &&
          tbl_proto[i] == w.proto && tbl_dport[i] == w.dest_port) begin
        r.entry_index = 4'(i);
        if (tbl_ban[i]) begin
          r.verdict = V_BLOCKED;
        end else begin
          if (tbl_cnt[i] != COUNT_MAX) tbl_cnt[i] = tbl_cnt[i] + 1;
          r.verdict = V_COUNTED;
        end
        r.packet_count = tbl_cnt[i];
        return r;
      end
    end
    if (fill_cnt < TABLE_DEPTH) begin
      tbl_sip[fill_cnt] = w.source_ip;
      tbl_dip[fill_cnt] = w.dest_ip;
      tbl_proto[fill_cnt] = w.proto;
      tbl_dport[fill_cnt] = w.dest_port;
      tbl_cnt[fill_cnt] = 32'd1;
      tbl_ban[fill_cnt] = 1'b0;
      r.verdict = V_NEW;
      r.entry_index = 4'(fill_cnt);
      r.packet_count = 32'd1;
      fill_cnt++;
    end else begin
      r.verdict = V_FULL;
    end
    return r;
  endfunction

  function automatic fw_word_t pkt(input logic [15:0] et, input logic [31:0] sip,
                                   input logic [31:0] dip, input logic [7:0] pr,
                                   input logic [15:0] sp, input logic [15:0] dp);
    fw_word_t w;
    w.req_type = REQ_PACKET;
    w.ether_type = et;
    w.source_ip = sip;
    w.dest_ip = dip;
    w.proto = pr;
    w.source_port = sp;
    w.dest_port = dp;
    w.ban_index = 4'($urandom);
    return w;
  endfunction

  // packet fields ride along with random content
  function automatic fw_word_t ban(input logic [3:0] idx);
    fw_word_t w;
    w = pkt(16'($urandom), $urandom, $urandom, 8'($urandom), 16'($urandom), 16'($urandom));
    w.req_type = REQ_BAN;
    w.ban_index = idx;
    return w;
  endfunction

  function automatic void row(input fw_word_t w, input bit typed, input verdict_t v,
                              input logic [3:0] idx, input logic [31:0] cnt);
    plan_row_t p;
    p.word = w;
    p.typed = typed;
    p.outcome.verdict = v;
    p.outcome.entry_index = idx;
    p.outcome.packet_count = cnt;
    plan.push_back(p);
  endfunction

  function automatic fw_word_t roll_word();
    fw_word_t w;
    int unsigned pick;
    int unsigned slot;
    w = pkt(ETHER_IPV4, $urandom, $urandom, 8'($urandom), 16'($urandom), 16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      w.req_type = REQ_BAN;
      w.ether_type = 16'($urandom);
      // keep most bans off the low entries so counting stays alive
      w.ban_index = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(8, 15));
    end else if (pick < 8) begin
      w.ether_type = 16'($urandom);
    end else if (pick < 11) begin
      w.ether_type = ETHER_IPV4 ^ (16'h1 << $urandom_range(0, 15));
    end else if (pick < 17) begin
      if ($urandom_range(0, 1) != 0) w.source_ip = local_m;
      else w.dest_ip = local_m;
    end else if (pick < 90 && fill_cnt != 0) begin
      slot = $urandom_range(0, fill_cnt - 1);
      w.source_ip = tbl_sip[slot];
      w.dest_ip = tbl_dip[slot];
      w.proto = tbl_proto[slot];
      w.dest_port = tbl_dport[slot];
      // near miss: flip one bit of the key
      if (pick >= 82) begin
        case ($urandom_range(0, 3))
          0: w.source_ip ^= 32'h1 << $urandom_range(0, 31);
          1: w.dest_ip ^= 32'h1 << $urandom_range(0, 31);
          2: w.proto ^= 8'h1 << $urandom_range(0, 7);
          default: w.dest_port ^= 16'h1 << $urandom_range(0, 15);
        endcase
      end
    end
    return w;
  endfunction

  task automatic push_word(input fw_word_t w, input bit typed, input fw_outcome_t fixed);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 6);
    end
    in_valid <= 1'b1;
    {req_type, ether_type, source_ip, dest_ip, proto, source_port, dest_port, ban_index} <= w;
    word_typed <= typed;
    word_fixed <= fixed;
    do @(posedge clk); while (!in_ready);
    burst_left--;
  endtask

  task automatic write_local(input logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk) begin : rx_pattern
    rx_mode_t m;
    if (rx_left == 0) begin
      m = rx_mode_t'($urandom_range(0, 3));
      rx_mode <= m;
      rx_left <= (m == RX_HOLD) ? $urandom_range(4, 40) : $urandom_range(16, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin : result_check
    fw_word_t    seen;
    fw_outcome_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result word: verdict %0d index %0d count %0d",
                     verdict, entry_index, packet_count);
        end else begin
          want = outcome_q.pop_front();
          if (verdict !== want.verdict || entry_index !== want.entry_index ||
              packet_count !== want.packet_count) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("result mismatch: got verdict %0d index %0d count %0d, want %0d %0d %0d",
                       verdict, entry_index, packet_count,
                       want.verdict, want.entry_index, want.packet_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        seen = {req_type, ether_type, source_ip, dest_ip, proto, source_port, dest_port,
                ban_index};
        want = classify_word(seen);
        if (word_typed) want = word_fixed;
        outcome_q.push_back(want);
      end
      if (cfg_valid && cfg_ready) local_m = cfg_data;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    fw_outcome_t none;
    logic [31:0] addr;
    none = '0;
    row(ban(4'd0), 1'b1, V_BAN_IGNORED, 4'd0, 32'd0);
    row(ban(4'd15), 1'b1, V_BAN_IGNORED, 4'd0, 32'd0);
    row(pkt(16'h0000, HOST_A, HOST_B, 8'd6, 16'd1024, 16'd80), 1'b1, V_NOT_IPV4, 4'd0, 32'd0);
    row(pkt(16'hFFFF, HOST_A, HOST_B, 8'd6, 16'd1024, 16'd80), 1'b1, V_NOT_IPV4, 4'd0, 32'd0);
    row(pkt(16'h0801, HOST_A, HOST_B, 8'd6, 16'd1024, 16'd80), 1'b1, V_NOT_IPV4, 4'd0, 32'd0);
    row(pkt(ETHER_IPV4, LOCAL_RESET, HOST_B, 8'd6, 16'd1024, 16'd80), 1'b1, V_LOCAL, 4'd0,
        32'd0);
    row(pkt(ETHER_IPV4, HOST_A, LOCAL_RESET, 8'd17, 16'd53, 16'd53), 1'b1, V_LOCAL, 4'd0,
        32'd0);
    row(pkt(ETHER_IPV4, 32'd0, 32'd0, 8'd0, 16'd0, 16'd0), 1'b1, V_NEW, 4'd0, 32'd1);
    // source port is not part of the key
    row(pkt(ETHER_IPV4, 32'd0, 32'd0, 8'd0, 16'hFFFF, 16'd0), 1'b1, V_COUNTED, 4'd0, 32'd2);
    row(pkt(ETHER_IPV4, ALL_ONES, ALL_ONES, 8'hFF, 16'hFFFF, 16'hFFFF), 1'b1, V_NEW, 4'd1,
        32'd1);
    row(pkt(ETHER_IPV4, ALL_ONES, ALL_ONES, 8'hFF, 16'h0000, 16'hFFFF), 1'b1, V_COUNTED, 4'd1,
        32'd2);
    row(pkt(ETHER_IPV4, ALL_ONES, ALL_ONES, 8'hFF, 16'hFFFF, 16'hFFFE), 1'b1, V_NEW, 4'd2,
        32'd1);
    row(pkt(ETHER_IPV4, ALL_ONES, ALL_ONES, 8'hFE, 16'hFFFF, 16'hFFFF), 1'b1, V_NEW, 4'd3,
        32'd1);
    row(pkt(ETHER_IPV4, HOST_A, HOST_B, 8'd6, 16'd1024, 16'd80), 1'b1, V_NEW, 4'd4, 32'd1);
    row(pkt(ETHER_IPV4, HOST_B, HOST_A, 8'd6, 16'd80, 16'd80), 1'b1, V_NEW, 4'd5, 32'd1);
    row(ban(4'd1), 1'b1, V_BANNED, 4'd1, 32'd2);
    row(ban(4'd1), 1'b1, V_BANNED, 4'd1, 32'd2);
    row(pkt(ETHER_IPV4, ALL_ONES, ALL_ONES, 8'hFF, 16'd1234, 16'hFFFF), 1'b1, V_BLOCKED, 4'd1,
        32'd2);
    row(ban(4'd6), 1'b1, V_BAN_IGNORED, 4'd0, 32'd0);
    row(ban(4'd5), 1'b1, V_BANNED, 4'd5, 32'd1);
    row(pkt(ETHER_IPV4, HOST_B, HOST_A, 8'd6, 16'd80, 16'd80), 1'b1, V_BLOCKED, 4'd5, 32'd1);
    row(pkt(ETHER_IPV4, HOST_A, HOST_B, 8'd6, 16'd9999, 16'd80), 1'b1, V_COUNTED, 4'd4, 32'd2);
    // ether type is judged before the local address
    row(pkt(16'h8800, HOST_A, LOCAL_RESET, 8'd6, 16'd1024, 16'd80), 1'b1, V_NOT_IPV4, 4'd0,
        32'd0);
    row(pkt(ETHER_IPV4, $urandom, $urandom, 8'($urandom), 16'($urandom), 16'($urandom)),
        1'b0, V_NOT_IPV4, 4'd0, 32'd0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (plan[k]) push_word(plan[k].word, plan[k].typed, plan[k].outcome);
    in_valid <= 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      // hold off until the table has answered every word
      do @(posedge clk); while (outcome_q.size() != 0);
      case (phase)
        0: addr = 32'h0000_0000;
        1: addr = ALL_ONES;
        2: addr = tbl_dip[4];
        4: addr = LOCAL_RESET;
        default: addr = $urandom;
      endcase
      write_local(addr);
      repeat (WORDS_PER_PHASE) push_word(roll_word(), 1'b0, none);
      in_valid <= 1'b0;
    end

    do @(posedge clk); while (outcome_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && outcome_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
